// ===== hdl/lclg_pkg.sv =====
// Shared types, constants and codes for the LED current limit governor.
package lclg_pkg;

  // Level step per tick, recovery wait, and stuck-at-zero limit
  localparam int unsigned STEP_AUTO       = 2;
  localparam int unsigned RECOVERY_TICKS  = 20;
  localparam int unsigned ZERO_HOLD_LIMIT = 200;

  // Configuration port geometry
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_CATASTROPHIC = 3'd0,
    CFG_LOW          = 3'd1,
    CFG_HIGH         = 3'd2,
    CFG_CEILING      = 3'd3,
    CFG_DESIRED      = 3'd4,
    CFG_AUTO_ENABLE  = 3'd5
  } cfg_reg_e;

  // Driver command codes
  typedef enum logic [1:0] {
    DRV_NONE    = 2'd0,
    DRV_DISABLE = 2'd1,
    DRV_ENABLE  = 2'd2
  } drv_cmd_e;

  // Level move chosen for one tick
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_RISE,
    ACT_LOWER
  } action_e;

  typedef struct packed {
    logic [15:0] catastrophic_threshold;
    logic [15:0] low_threshold;
    logic [15:0] high_threshold;
    logic [7:0]  level_ceiling;
    logic [7:0]  desired_level;
    logic        auto_enable;
  } lclg_cfg_t;

  typedef struct packed {
    logic [15:0] supply_now;
    logic [15:0] supply_average;
    logic        breathing;
    logic [7:0]  breathe_level_in;
    logic        extra_port_on;
  } lclg_item_t;

  typedef struct packed {
    logic [7:0] level;
    logic [4:0] recovery_count;
    logic [7:0] zero_hold_count;
    logic       forced_auto;
  } lclg_state_t;

  typedef struct packed {
    logic [7:0] current_level;
    drv_cmd_e   driver_command;
    logic       extra_port_cut;
    logic [7:0] breathe_level_out;
    logic       auto_active;
  } lclg_res_t;

endpackage

// ===== hdl/lclg_in_if.sv =====
// Input channel: one supply tick per beat.
interface lclg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] supply_now;
  logic [15:0] supply_average;
  logic        breathing;
  logic [7:0]  breathe_level_in;
  logic        extra_port_on;

  modport source (
    output valid, supply_now, supply_average, breathing, breathe_level_in, extra_port_on,
    input  ready
  );
  modport sink (
    input  valid, supply_now, supply_average, breathing, breathe_level_in, extra_port_on,
    output ready
  );
endinterface

// ===== hdl/lclg_out_if.sv =====
// Output channel: one governor result per beat.
interface lclg_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] current_level;
  logic [1:0] driver_command;
  logic       extra_port_cut;
  logic [7:0] breathe_level_out;
  logic       auto_active;

  modport source (
    output valid, current_level, driver_command, extra_port_cut, breathe_level_out,
           auto_active,
    input  ready
  );
  modport sink (
    input  valid, current_level, driver_command, extra_port_cut, breathe_level_out,
           auto_active,
    output ready
  );
endinterface

// ===== hdl/lclg_step.sv =====
// Combinational tick update: next governor state and the result for one beat.
module lclg_step import lclg_pkg::*; (
  input  lclg_item_t  item,
  input  lclg_cfg_t   cfg,
  input  lclg_state_t state,
  output lclg_state_t state_next,
  output lclg_res_t   res
);

  logic [7:0] target;
  logic       auto_on;
  action_e    action;
  logic [8:0] rise_sum;
  logic [7:0] hold_inc;
  drv_cmd_e   cmd;
  logic       cut;
  logic [7:0] breathe_out;

  assign target   = item.breathing ? item.breathe_level_in : cfg.desired_level;
  assign auto_on  = cfg.auto_enable | state.forced_auto;
  assign rise_sum = {1'b0, state.level} + 9'(STEP_AUTO);
  assign hold_inc = (state.zero_hold_count != '1) ? state.zero_hold_count + 8'd1
                                                  : state.zero_hold_count;

  // Pick the level move from the target and, in auto mode, the supply average
  always_comb begin
    action = ACT_NONE;
    if (auto_on) begin
      if (item.supply_average < cfg.low_threshold) begin
        action = ACT_LOWER;
      end else if (item.supply_average > cfg.high_threshold && state.level < target) begin
        action = ACT_RISE;
      end else if (state.level > target) begin
        action = ACT_LOWER;
      end
    end else begin
      if (state.level < target) begin
        action = ACT_RISE;
      end else if (state.level > target) begin
        action = ACT_LOWER;
      end
    end
  end

  // Apply catastrophe, recovery wait, or the chosen move
  always_comb begin
    state_next  = state;
    cmd         = DRV_NONE;
    cut         = 1'b0;
    breathe_out = item.breathe_level_in;
    if (item.supply_now < cfg.catastrophic_threshold) begin
      cmd                        = DRV_DISABLE;
      state_next.recovery_count  = 5'(RECOVERY_TICKS);
      state_next.level           = '0;
      state_next.forced_auto     = 1'b1;
    end else if (state.recovery_count > 5'd1) begin
      state_next.recovery_count = state.recovery_count - 5'd1;
    end else if (state.recovery_count == 5'd1) begin
      cmd                       = DRV_ENABLE;
      state_next.recovery_count = '0;
    end else begin
      case (action)
        ACT_NONE: begin
          state_next.zero_hold_count = '0;
        end
        ACT_RISE: begin
          if (rise_sum > {1'b0, cfg.level_ceiling}) begin
            state_next.level = cfg.level_ceiling;
          end else begin
            state_next.level = rise_sum[7:0];
          end
          state_next.zero_hold_count = '0;
        end
        ACT_LOWER: begin
          if (state.level < 8'(STEP_AUTO)) begin
            // stuck at zero: count ticks while the extra port is on
            state_next.level = '0;
            if (item.extra_port_on) begin
              state_next.zero_hold_count = hold_inc;
              cut = (hold_inc > 8'(ZERO_HOLD_LIMIT));
            end
          end else begin
            state_next.level           = state.level - 8'(STEP_AUTO);
            state_next.zero_hold_count = '0;
            if (item.breathing) begin
              breathe_out = state.level - 8'(STEP_AUTO);
            end
          end
        end
        default: begin
          state_next.zero_hold_count = '0;
        end
      endcase
    end
  end

  // Assemble the result beat
  always_comb begin
    res.current_level     = state_next.level;
    res.driver_command    = cmd;
    res.extra_port_cut    = cut;
    res.breathe_level_out = breathe_out;
    res.auto_active       = cfg.auto_enable | state_next.forced_auto;
  end

endmodule

// ===== hdl/led_current_limit_governor.sv =====
// Top level of the LED current limit governor: config registers, pipeline and state.
//
//   channel  direction  handshake      payload
//   item     sink       valid/ready    supply_now, supply_average, breathing,
//                                      breathe_level_in, extra_port_on
//   result   source     valid/ready    current_level, driver_command, extra_port_cut,
//                                      breathe_level_out, auto_active
//   cfg      write      cfg_write      cfg_index, cfg_data (no read-back)
//
// Each beat passes through the input register and then the result register, one beat
// per cycle sustained while the result side is ready. The tick update sits between the two.
// Reset (rst, synchronous) clears the state, empties both stages and loads the
// register defaults. A stalled result holds the result register; the input register
// still takes a beat while the result register is full and the input stage is empty.
module led_current_limit_governor import lclg_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  lclg_in_if.sink                item,
  lclg_out_if.source             result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  lclg_cfg_t   cfg;
  lclg_state_t state;
  lclg_state_t state_next;
  lclg_item_t  hold;
  logic        hold_valid;
  lclg_item_t  item_beat;
  lclg_res_t   res_next;
  lclg_res_t   res;
  logic        res_valid;
  logic        advance;

  assign advance    = hold_valid && (!res_valid || result.ready);
  assign item.ready = !hold_valid || advance;

  assign item_beat.supply_now       = item.supply_now;
  assign item_beat.supply_average   = item.supply_average;
  assign item_beat.breathing        = item.breathing;
  assign item_beat.breathe_level_in = item.breathe_level_in;
  assign item_beat.extra_port_on    = item.extra_port_on;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.catastrophic_threshold <= '0;
      cfg.low_threshold          <= '0;
      cfg.high_threshold         <= '0;
      cfg.level_ceiling          <= 8'hFF;
      cfg.desired_level          <= '0;
      cfg.auto_enable            <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CATASTROPHIC: cfg.catastrophic_threshold <= cfg_data;
        CFG_LOW:          cfg.low_threshold          <= cfg_data;
        CFG_HIGH:         cfg.high_threshold         <= cfg_data;
        CFG_CEILING:      cfg.level_ceiling          <= cfg_data[7:0];
        CFG_DESIRED:      cfg.desired_level          <= cfg_data[7:0];
        CFG_AUTO_ENABLE:  cfg.auto_enable            <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Capture the input beat
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (item.ready) begin
      hold_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      hold <= item_beat;
    end
  end

  lclg_step u_step (
    .item       (hold),
    .cfg        (cfg),
    .state      (state),
    .state_next (state_next),
    .res        (res_next)
  );

  // Advance governor state; an auto_enable write drops forced auto
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (cfg_write && cfg_index == CFG_AUTO_ENABLE) begin
      state.forced_auto <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || result.ready) begin
      res_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign result.valid             = res_valid;
  assign result.current_level     = res.current_level;
  assign result.driver_command    = res.driver_command;
  assign result.extra_port_cut    = res.extra_port_cut;
  assign result.breathe_level_out = res.breathe_level_out;
  assign result.auto_active       = res.auto_active;

  // A driver cut always comes with the level at zero
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.driver_command == DRV_DISABLE |-> res.current_level == 8'd0)
    else $error("driver disable with nonzero level");

  // An extra port cut is only requested while the level sits at zero
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.extra_port_cut |-> res.current_level == 8'd0 &&
      res.driver_command == DRV_NONE)
    else $error("extra port cut with level above zero");

  // The recovery wait never exceeds its start value
  assert property (@(posedge clk) disable iff (rst)
    state.recovery_count <= 5'(RECOVERY_TICKS))
    else $error("recovery count out of range");

  // A disable command leaves forced auto mode set
  assert property (@(posedge clk) disable iff (rst)
    advance && res_next.driver_command == DRV_DISABLE && !cfg_write |=> state.forced_auto)
    else $error("forced auto not set after catastrophe");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the LED current limit governor.
module tb_top;
  import lclg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STALL_LIMIT = 1000;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  lclg_in_if  item_ch ();
  lclg_out_if res_ch ();

  led_current_limit_governor i_dut (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (res_ch),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow registers and governor state
  int unsigned cfg_cat, cfg_low, cfg_high, cfg_ceiling, cfg_desired, cfg_auto;
  int unsigned gov_level, gov_recovery, gov_zero_hold, gov_forced;

  lclg_res_t   expected_ticks[$];
  int unsigned mismatch_count;
  bit          send_gaps;
  bit          recv_stalls;
  int unsigned hold_off_cycles;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void reset_governor();
    cfg_cat       = 0;
    cfg_low       = 0;
    cfg_high      = 0;
    cfg_ceiling   = 255;
    cfg_desired   = 0;
    cfg_auto      = 1;
    gov_level     = 0;
    gov_recovery  = 0;
    gov_zero_hold = 0;
    gov_forced    = 0;
  endfunction

  // One governor tick: update the shadow state and return the result it gives
  function automatic lclg_res_t govern_tick(lclg_item_t t);
    lclg_res_t   r;
    int unsigned tgt;
    action_e     act;
    drv_cmd_e    cmd;
    logic [7:0]  breathe;
    logic        cut;
    tgt     = t.breathing ? t.breathe_level_in : cfg_desired;
    act     = ACT_NONE;
    cmd     = DRV_NONE;
    breathe = t.breathe_level_in;
    cut     = 1'b0;
    if (t.supply_now < cfg_cat) begin
      // sag: cut drivers and start the recovery wait
      cmd          = DRV_DISABLE;
      gov_recovery = RECOVERY_TICKS;
      gov_level    = 0;
      gov_forced   = 1;
    end else if (gov_recovery > 1) begin
      gov_recovery--;
    end else if (gov_recovery == 1) begin
      cmd          = DRV_ENABLE;
      gov_recovery = 0;
    end else begin
      if (cfg_auto != 0 || gov_forced != 0) begin
        if (t.supply_average < cfg_low) act = ACT_LOWER;
        else if (t.supply_average > cfg_high && gov_level < tgt) act = ACT_RISE;
        else if (gov_level > tgt) act = ACT_LOWER;
      end else begin
        if (gov_level < tgt) act = ACT_RISE;
        else if (gov_level > tgt) act = ACT_LOWER;
      end
      case (act)
        ACT_NONE: begin
          gov_zero_hold = 0;
        end
        ACT_RISE: begin
          if (gov_level + STEP_AUTO > cfg_ceiling) gov_level = cfg_ceiling;
          else gov_level = gov_level + STEP_AUTO;
          gov_zero_hold = 0;
        end
        default: begin
          if (gov_level < STEP_AUTO) begin
            // stuck at zero: count while the extra port is on
            gov_level = 0;
            if (t.extra_port_on) begin
              if (gov_zero_hold < 255) gov_zero_hold++;
              if (gov_zero_hold > ZERO_HOLD_LIMIT) cut = 1'b1;
            end
          end else begin
            gov_level     = gov_level - STEP_AUTO;
            gov_zero_hold = 0;
            if (t.breathing) breathe = gov_level[7:0];
          end
        end
      endcase
    end
    r.current_level     = gov_level[7:0];
    r.driver_command    = cmd;
    r.extra_port_cut    = cut;
    r.breathe_level_out = breathe;
    r.auto_active       = (cfg_auto != 0) || (gov_forced != 0);
    return r;
  endfunction

  function automatic lclg_item_t make_tick(int unsigned now, int unsigned avg, bit br,
                                           int unsigned bl, bit port);
    lclg_item_t t;
    t.supply_now       = now[15:0];
    t.supply_average   = avg[15:0];
    t.breathing        = br;
    t.breathe_level_in = bl[7:0];
    t.extra_port_on    = port;
    return t;
  endfunction

  // Random tick, biased around the current thresholds
  function automatic lclg_item_t random_tick();
    int unsigned now, avg, bl;
    if (cfg_cat != 0 && $urandom_range(0, 24) != 0) now = $urandom_range(cfg_cat, 65535);
    else now = $urandom_range(0, 65535);
    case ($urandom_range(0, 2))
      0: avg = (cfg_low > 0) ? $urandom_range(0, cfg_low - 1) : 0;
      1: avg = (cfg_high < 65535) ? $urandom_range(cfg_high + 1, 65535) : 65535;
      default: avg = $urandom_range(0, 65535);
    endcase
    case ($urandom_range(0, 7))
      0: bl = 0;
      1: bl = 255;
      default: bl = $urandom_range(0, 255);
    endcase
    return make_tick(now, avg, 1'($urandom_range(0, 1)), bl, 1'($urandom_range(0, 1)));
  endfunction

  function automatic int unsigned pick16();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Send one tick; valid stays high after the beat unless a gap follows
  task automatic send_tick(lclg_item_t t);
    int unsigned gap;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid            <= 1'b1;
    item_ch.supply_now       <= t.supply_now;
    item_ch.supply_average   <= t.supply_average;
    item_ch.breathing        <= t.breathing;
    item_ch.breathe_level_in <= t.breathe_level_in;
    item_ch.extra_port_on    <= t.extra_port_on;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    expected_ticks.push_back(govern_tick(t));
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic settle_idle();
    item_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, int unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[15:0];
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_CATASTROPHIC: cfg_cat     = val & 16'hFFFF;
      CFG_LOW:          cfg_low     = val & 16'hFFFF;
      CFG_HIGH:         cfg_high    = val & 16'hFFFF;
      CFG_CEILING:      cfg_ceiling = val & 8'hFF;
      CFG_DESIRED:      cfg_desired = val & 8'hFF;
      CFG_AUTO_ENABLE: begin
        cfg_auto   = val & 1;
        gov_forced = 0;
      end
      default: ;
    endcase
  endtask

  task automatic write_all(int unsigned cat, int unsigned low, int unsigned high,
                           int unsigned ceil, int unsigned desired, int unsigned auto_on);
    settle_idle();
    write_reg(CFG_CATASTROPHIC, cat);
    write_reg(CFG_LOW, low);
    write_reg(CFG_HIGH, high);
    write_reg(CFG_CEILING, ceil);
    write_reg(CFG_DESIRED, desired);
    write_reg(CFG_AUTO_ENABLE, auto_on);
  endtask

  // Field extremes, manual and auto moves, ceiling clamp, breathe update, sag
  task automatic test_directed();
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    write_all(1000, 3000, 5000, 7, 255, 0);
    send_tick(make_tick(65535, 0, 0, 0, 0));
    send_tick(make_tick(65535, 65535, 0, 0, 1));
    send_tick(make_tick(5000, 3000, 0, 0, 0));
    send_tick(make_tick(1000, 5000, 0, 0, 0));
    send_tick(make_tick(65535, 0, 0, 0, 0));
    send_tick(make_tick(65535, 0, 1, 0, 0));
    send_tick(make_tick(65535, 0, 1, 255, 1));
    // rise with the level above a lowered ceiling pulls it down
    settle_idle();
    write_reg(CFG_CEILING, 3);
    send_tick(make_tick(65535, 65535, 0, 255, 0));
    settle_idle();
    write_reg(CFG_DESIRED, 0);
    send_tick(make_tick(65535, 0, 0, 0, 1));
    send_tick(make_tick(65535, 0, 0, 0, 1));
    send_tick(make_tick(65535, 0, 0, 0, 0));
    // auto mode: high average rises toward the target, low average lowers
    settle_idle();
    write_reg(CFG_AUTO_ENABLE, 1);
    send_tick(make_tick(65535, 5001, 1, 200, 0));
    send_tick(make_tick(65535, 5001, 1, 200, 1));
    send_tick(make_tick(65535, 2999, 1, 200, 1));
    send_tick(make_tick(65535, 5000, 0, 0, 1));
    send_tick(make_tick(999, 5001, 0, 0, 0));
    send_tick(make_tick(0, 65535, 1, 255, 1));
    send_tick(make_tick(65535, 65535, 1, 255, 1));
    // forced auto overrides software manual mode until auto_enable is written
    settle_idle();
    write_reg(CFG_AUTO_ENABLE, 0);
    write_reg(CFG_CATASTROPHIC, 1);
    send_tick(make_tick(0, 0, 0, 0, 0));
    repeat (20) send_tick(make_tick(1, 0, 1, 255, 1));
    send_tick(make_tick(65535, 0, 1, 255, 1));
  endtask

  // Random ticks over a spread of register settings
  task automatic test_random_mix();
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: write_all(0, 0, 0, 0, 0, 0);
        1: write_all(65535, 65535, 65535, 255, 255, 1);
        default: write_all(($urandom_range(0, 5) == 0) ? pick16() : $urandom_range(0, 4000),
                           pick16(), pick16(), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 1));
      endcase
      send_gaps   = (ph % 3) != 2;
      recv_stalls = (ph % 3) != 1;
      repeat (120) send_tick(random_tick());
    end
  endtask

  // Hold the level at zero long enough to request the extra port cut
  task automatic test_stuck_zero();
    lclg_item_t t;
    write_all(0, 65535, 65535, 255, $urandom_range(0, 255), 1);
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    repeat (240) begin
      t = random_tick();
      t.supply_average = 16'($urandom_range(0, 65534));
      t.extra_port_on  = ($urandom_range(0, 9) != 0);
      send_tick(t);
    end
  endtask

  // Hold off the result side so the block fills and stalls its input
  task automatic test_backpressure();
    write_all($urandom_range(0, 2000), $urandom_range(0, 30000), $urandom_range(0, 65535),
              $urandom_range(100, 255), $urandom_range(0, 255), 1);
    send_gaps       = 1'b0;
    recv_stalls     = 1'b0;
    hold_off_cycles = 60;
    repeat (60) send_tick(random_tick());
  endtask

  // Full rate on both sides to finish
  task automatic test_no_idle();
    write_all($urandom_range(0, 3000), pick16(), pick16(), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(0, 1));
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    repeat (200) send_tick(random_tick());
  endtask

  // Result side ready: random stall bursts and long hold-offs
  initial begin : result_ready_drive
    int unsigned stall_left;
    stall_left   = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        res_ch.ready    <= 1'b0;
        hold_off_cycles = hold_off_cycles - 1;
      end else if (stall_left > 0) begin
        res_ch.ready <= 1'b0;
        stall_left   = stall_left - 1;
      end else if (recv_stalls && $urandom_range(0, 4) == 0) begin
        res_ch.ready <= 1'b0;
        stall_left   = $urandom_range(0, 5);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Compare each result beat with the oldest expected tick
  always @(posedge clk) begin : result_check
    lclg_res_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_ticks.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual level %0d", $time,
                 res_ch.current_level);
      end else begin
        want = expected_ticks.pop_front();
        check_field("current_level", 16'(want.current_level), 16'(res_ch.current_level));
        check_field("driver_command", 16'(want.driver_command),
                    16'(res_ch.driver_command));
        check_field("extra_port_cut", 16'(want.extra_port_cut),
                    16'(res_ch.extra_port_cut));
        check_field("breathe_level_out", 16'(want.breathe_level_out),
                    16'(res_ch.breathe_level_out));
        check_field("auto_active", 16'(want.auto_active), 16'(res_ch.auto_active));
      end
    end
  end

  // Watchdog: end the run when no beat moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
          (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    mismatch_count   = 0;
    send_gaps        = 1'b0;
    recv_stalls      = 1'b0;
    hold_off_cycles  = 0;
    rst                      <= 1'b1;
    cfg_write                <= 1'b0;
    cfg_index                <= CFG_CATASTROPHIC;
    cfg_data                 <= '0;
    item_ch.valid            <= 1'b0;
    item_ch.supply_now       <= '0;
    item_ch.supply_average   <= '0;
    item_ch.breathing        <= 1'b0;
    item_ch.breathe_level_in <= '0;
    item_ch.extra_port_on    <= 1'b0;
    reset_governor();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_mix();
    test_stuck_zero();
    test_backpressure();
    test_no_idle();

    // Drain the pipeline, then wait for stray beats
    settle_idle();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && expected_ticks.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/lclg_pkg.sv
hdl/lclg_in_if.sv
hdl/lclg_out_if.sv
hdl/lclg_step.sv
hdl/led_current_limit_governor.sv
tb/tb_top.sv
